>>> hdl/anbs_pkg.sv
// Shared types, constants and helpers of the Annex B start code splitter.
`timescale 1ns / 1ps

package anbs_pkg;

   localparam int unsigned LEN_FIELD_BITS = 24;
   localparam logic [LEN_FIELD_BITS-1:0] FIELD_MAX = 24'hFF_FFFF;

   localparam int unsigned FIFO_DEPTH    = 8;
   localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
   // room for the word in the input register plus the next one, two results each
   localparam logic [FIFO_CNT_BITS-1:0] FIFO_READY_LIMIT = FIFO_CNT_BITS'(FIFO_DEPTH - 4);

   localparam logic [7:0] START_CODE_END = 8'h01;
   localparam logic [7:0] ZERO_BYTE      = 8'h00;

   localparam logic [4:0] NAL_SLICE = 5'd1;
   localparam logic [4:0] NAL_IDR   = 5'd5;
   localparam logic [4:0] NAL_SEI   = 5'd6;
   localparam logic [4:0] NAL_SPS   = 5'd7;
   localparam logic [4:0] NAL_PPS   = 5'd8;
   localparam logic [3:0] NAL_OTHER = 4'd0;

   localparam logic [2:0] PREFIX_SHORT = 3'd3;
   localparam logic [2:0] PREFIX_LONG  = 3'd4;

   localparam logic STATUS_COMPLETE  = 1'b0;
   localparam logic STATUS_TRUNCATED = 1'b1;

   localparam logic [2:0] ZERO_RUN_MAX = 3'd4;

   typedef struct packed {
      logic [3:0]                nal_type;
      logic [2:0]                prefix_length;
      logic [LEN_FIELD_BITS-1:0] unit_length;
      logic                      status;
      logic                      last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

   function automatic logic [3:0] map_type(input logic [7:0] header);
      logic [4:0] t;
      t = header[4:0];
      if (t == NAL_SLICE || t == NAL_IDR || t == NAL_SEI || t == NAL_SPS || t == NAL_PPS)
         return t[3:0];
      return NAL_OTHER;
   endfunction

endpackage

>>> hdl/anbs_req_if.sv
// Stream byte channel: valid, ready and one byte with its end marker.
`timescale 1ns / 1ps

interface anbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

>>> hdl/anbs_rsp_if.sv
// Unit descriptor channel: valid, ready and one result word.
`timescale 1ns / 1ps

interface anbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  nal_type;
   logic [2:0]  prefix_length;
   logic [23:0] unit_length;
   logic        status;
   logic        last_of_run;

   modport source (output valid, output nal_type, output prefix_length, output unit_length,
                   output status, output last_of_run, input ready);
   modport sink (input valid, input nal_type, input prefix_length, input unit_length,
                 input status, input last_of_run, output ready);
endinterface

>>> hdl/annexb_nal_unit_splitter.sv
// Annex B start code splitter top level: input register, scanner and result queue.
//
//   channel   dir   handshake            word
//   req_if    in    valid/ready          data_byte[7:0], end_of_stream
//   rsp_if    out   valid/ready          nal_type, prefix_length, unit_length, status,
//                                        last_of_run
//
// One byte per cycle sustained while req_if.ready is high; a byte sits in the input register in the cycle
// after acceptance and its results enter the 8-word queue at the end of that cycle.
// A byte closing a unit at end of stream yields two words, drained one per cycle while rsp_if.ready is high.
// req_if.ready drops while the queue holds more than four words.
// Synchronous reset clears the scanner state and the queue.
`timescale 1ns / 1ps

module annexb_nal_unit_splitter
   import anbs_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic     clock,
   input  logic     reset,
   anbs_req_if.sink   req_if,
   anbs_rsp_if.source rsp_if
);

   logic                     s1_valid_ff, s1_valid_in;
   logic [7:0]               s1_byte_ff;
   logic                     s1_eos_ff;
   logic [FIFO_CNT_BITS-1:0] fill;
   push_type                 push;

   assign req_if.ready = (fill <= FIFO_READY_LIMIT);
   assign s1_valid_in  = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_byte_ff <= req_if.data_byte;
      s1_eos_ff  <= req_if.end_of_stream;
   end

   anbs_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item_byte  (s1_byte_ff),
      .item_eos   (s1_eos_ff),
      .push       (push)
   );

   anbs_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .fill   (fill),
      .rsp_if (rsp_if)
   );

endmodule

>>> hdl/anbs_parser.sv
// Start code scanner: unit state registers and the per-byte update logic.
`timescale 1ns / 1ps

module anbs_parser
   import anbs_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  logic [7:0] item_byte,
   input  logic       item_eos,
   output push_type   push
);

   localparam int unsigned LB = LENGTH_BITS;
   localparam logic [LB-1:0] LEN_CAP =
      (LENGTH_BITS >= LEN_FIELD_BITS) ? LB'(FIELD_MAX) : {LB{1'b1}};
   localparam logic [LB-1:0] LEN_TWO   = LB'(2);
   localparam logic [LB-1:0] LEN_THREE = LB'(3);
   localparam logic [LB-1:0] LEN_FOUR  = LB'(4);

   logic [2:0]    zero_run_ff, zero_run_in;
   logic          in_unit_ff, in_unit_in;
   logic          awaiting_header_ff, awaiting_header_in;
   logic [3:0]    current_type_ff, current_type_in;
   logic          prefix_four_ff, prefix_four_in;
   logic [LB-1:0] byte_count_ff, byte_count_in;
   logic          tail_seen_ff, tail_seen_in;
   logic [LB-1:0] tail_position_ff, tail_position_in;

   logic          is_start;
   logic          new_four;
   logic [LB-1:0] back_off;
   logic [LB-1:0] close_len;
   logic          close_valid;
   logic          eos_valid;
   rsp_word_type  close_word;
   rsp_word_type  eos_word;

   always_comb begin
      is_start = (item_byte == START_CODE_END) && (zero_run_ff >= 3'd2);
      new_four = (zero_run_ff >= 3'd3);
      back_off = new_four ? LEN_THREE : LEN_TWO;

      priority if (byte_count_ff >= LEN_CAP) begin
         close_len = LEN_CAP;
      end else if (byte_count_ff >= back_off) begin
         close_len = byte_count_ff - back_off;
      end else begin
         close_len = '0;
      end
      close_valid = is_start && in_unit_ff;

      zero_run_in        = zero_run_ff;
      in_unit_in         = in_unit_ff;
      awaiting_header_in = awaiting_header_ff;
      current_type_in    = current_type_ff;
      prefix_four_in     = prefix_four_ff;
      byte_count_in      = byte_count_ff;
      tail_seen_in       = tail_seen_ff;
      tail_position_in   = tail_position_ff;

      if (is_start) begin
         in_unit_in         = 1'b1;
         awaiting_header_in = 1'b1;
         current_type_in    = NAL_OTHER;
         prefix_four_in     = new_four;
         byte_count_in      = new_four ? LEN_FOUR : LEN_THREE;
         tail_seen_in       = 1'b0;
         tail_position_in   = '0;
         zero_run_in        = '0;
      end else begin
         if (in_unit_ff) begin
            if (awaiting_header_ff) begin
               current_type_in    = map_type(item_byte);
               awaiting_header_in = 1'b0;
            end
            if (item_byte == ZERO_BYTE && zero_run_ff == 3'd3 && !tail_seen_ff) begin
               tail_seen_in = 1'b1;
               priority if (byte_count_ff >= LEN_CAP) begin
                  tail_position_in = LEN_CAP;
               end else if (byte_count_ff >= LEN_THREE) begin
                  tail_position_in = byte_count_ff - LEN_THREE;
               end else begin
                  tail_position_in = '0;
               end
            end
            if (byte_count_ff < LEN_CAP) begin
               byte_count_in = byte_count_ff + LB'(1);
            end
         end
         if (item_byte == ZERO_BYTE) begin
            zero_run_in = (zero_run_ff < ZERO_RUN_MAX) ? zero_run_ff + 3'd1 : ZERO_RUN_MAX;
         end else begin
            zero_run_in = '0;
         end
      end

      eos_valid = item_eos && in_unit_in;

      close_word.nal_type      = current_type_ff;
      close_word.prefix_length = prefix_four_ff ? PREFIX_LONG : PREFIX_SHORT;
      close_word.unit_length   = LEN_FIELD_BITS'(close_len);
      close_word.status        = STATUS_COMPLETE;
      close_word.last_of_run   = !eos_valid;

      eos_word.nal_type      = current_type_in;
      eos_word.prefix_length = prefix_four_in ? PREFIX_LONG : PREFIX_SHORT;
      eos_word.unit_length   = tail_seen_in ? LEN_FIELD_BITS'(tail_position_in)
                                            : LEN_FIELD_BITS'(byte_count_in);
      eos_word.status        = tail_seen_in ? STATUS_COMPLETE : STATUS_TRUNCATED;
      eos_word.last_of_run   = 1'b1;

      if (item_eos) begin
         zero_run_in        = '0;
         in_unit_in         = 1'b0;
         awaiting_header_in = 1'b0;
         current_type_in    = NAL_OTHER;
         prefix_four_in     = 1'b0;
         byte_count_in      = '0;
         tail_seen_in       = 1'b0;
         tail_position_in   = '0;
      end

      push.count  = item_valid ? ({1'b0, close_valid} + {1'b0, eos_valid}) : 2'd0;
      push.first  = close_valid ? close_word : eos_word;
      push.second = eos_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff        <= '0;
         in_unit_ff         <= 1'b0;
         awaiting_header_ff <= 1'b0;
         current_type_ff    <= NAL_OTHER;
         prefix_four_ff     <= 1'b0;
         byte_count_ff      <= '0;
         tail_seen_ff       <= 1'b0;
         tail_position_ff   <= '0;
      end else if (item_valid) begin
         zero_run_ff        <= zero_run_in;
         in_unit_ff         <= in_unit_in;
         awaiting_header_ff <= awaiting_header_in;
         current_type_ff    <= current_type_in;
         prefix_four_ff     <= prefix_four_in;
         byte_count_ff      <= byte_count_in;
         tail_seen_ff       <= tail_seen_in;
         tail_position_ff   <= tail_position_in;
      end
   end

   a_zero_run_bound: assert property (@(posedge clock) disable iff (reset)
      zero_run_ff <= ZERO_RUN_MAX)
      else $error("zero run beyond saturation");

   a_header_in_unit: assert property (@(posedge clock) disable iff (reset)
      (awaiting_header_ff || tail_seen_ff) |-> in_unit_ff)
      else $error("unit flags set with no open unit");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item_eos) |=> (!in_unit_ff && zero_run_ff == 3'd0))
      else $error("state not cleared after end of stream");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= LEN_CAP)
      else $error("byte count above cap");

endmodule

>>> hdl/anbs_rsp_fifo.sv
// Result queue: takes up to two words a cycle, hands out one word a cycle while rsp_if.ready is high.
`timescale 1ns / 1ps

module anbs_rsp_fifo
   import anbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  push_type                 push,
   output logic [FIFO_CNT_BITS-1:0] fill,
   anbs_rsp_if.source               rsp_if
);

   rsp_word_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     pop;
   rsp_word_type             head;

   always_comb begin
      pop       = rsp_if.valid && rsp_if.ready;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      count_in  = count_ff + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
      head      = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + FIFO_PTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign fill                 = count_ff;
   assign rsp_if.valid         = (count_ff != '0);
   assign rsp_if.nal_type      = head.nal_type;
   assign rsp_if.prefix_length = head.prefix_length;
   assign rsp_if.unit_length   = head.unit_length;
   assign rsp_if.status        = head.status;
   assign rsp_if.last_of_run   = head.last_of_run;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) + 32'(push.count)) <= FIFO_DEPTH)
      else $error("result queue overflow");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("fill count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == FIFO_PTR_BITS'(count_ff))
      else $error("pointers disagree with fill count");

endmodule
